// File: rtl/pis_pkg.sv
// Shared types, constants and helper functions for the particle integrator.
package pis_pkg;

	// Grid size in cells along each axis.
	localparam int GRID_X = 128;
	localparam int GRID_Y = 128;
	localparam int GRID_Z = 128;

	// Drag limits: squared speed at 100.0 and drag factor at 0.05.
	localparam logic [30:0] VSQ_MAX = 31'd1677721600;
	localparam logic [19:0] MUL_MAX = 20'd838861;

	// Configuration register indexes.
	localparam logic [2:0] REG_CONTROL  = 3'd0;
	localparam logic [2:0] REG_SHADE    = 3'd1;
	localparam logic [2:0] REG_MAGNETIC = 3'd2;
	localparam logic [2:0] REG_APOS     = 3'd3;
	localparam logic [2:0] REG_AAXIS    = 3'd4;
	localparam logic [2:0] REG_STRENGTH = 3'd5;

	// Edge modes and control bit positions.
	localparam logic [1:0] EDGE_WRAP  = 2'd0;
	localparam logic [1:0] EDGE_CLAMP = 2'd1;
	localparam int CTL_MAGNETIC = 2;
	localparam int CTL_ATTRACT  = 3;
	localparam int CTL_AXIS     = 4;

	// Configuration register file contents.
	typedef struct packed {
		logic [4:0]  control;
		logic [4:0]  shade_step;
		logic [62:0] magnetic;
		logic [62:0] apos;
		logic [62:0] aaxis;
		logic [31:0] strength;
	} cfg_t;

	// Per-particle record carried down the pipeline after lifetime and edge work.
	typedef struct packed {
		logic [2:0][23:0] p;
		logic [2:0][23:0] v;
		logic [2:0][23:0] vin;
		logic [7:0]       shade;
		logic [31:0]      elapsed;
		logic             dead;
		logic [23:0]      drag;
		logic [15:0]      dt;
		logic [31:0]      qs;
	} rec_t;

	// Grid size of one axis.
	function automatic int grid_of(input int k);
		int g;
		g = GRID_X;
		if (k == 1) g = GRID_Y;
		if (k == 2) g = GRID_Z;
		return g;
	endfunction

	// Saturate to signed 24 bits.
	function automatic logic [23:0] sat24(input logic signed [47:0] x);
		logic [23:0] r;
		r = x[23:0];
		if (x > 48'sd8388607) r = 24'h7FFFFF;
		if (x < -48'sd8388608) r = 24'h800000;
		return r;
	endfunction

	// Saturate to signed 28 bits.
	function automatic logic [27:0] sat28(input logic signed [47:0] x);
		logic [27:0] r;
		r = x[27:0];
		if (x > 48'sd134217727) r = 28'h7FFFFFF;
		if (x < -48'sd134217728) r = 28'h8000000;
		return r;
	endfunction

endpackage

// File: rtl/pis_cfg.sv
// Configuration register file of the particle integrator.
module pis_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [62:0]        cfg_wdata,
	output pis_pkg::cfg_t      cfg
);

	pis_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control    <= '0;
			cfg_q.shade_step <= 5'd1;
			cfg_q.magnetic   <= '0;
			cfg_q.apos       <= '0;
			cfg_q.aaxis      <= '0;
			cfg_q.strength   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pis_pkg::REG_CONTROL:  cfg_q.control    <= cfg_wdata[4:0];
				pis_pkg::REG_SHADE:    cfg_q.shade_step <= cfg_wdata[4:0];
				pis_pkg::REG_MAGNETIC: cfg_q.magnetic   <= cfg_wdata;
				pis_pkg::REG_APOS:     cfg_q.apos       <= cfg_wdata;
				pis_pkg::REG_AAXIS:    cfg_q.aaxis      <= cfg_wdata;
				pis_pkg::REG_STRENGTH: cfg_q.strength   <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/pis_front.sv
// Stages 1 and 2: lifetime decay, position step and edge treatment.
module pis_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [2:0][23:0]   pos,
	input  logic [2:0][23:0]   vel,
	input  logic [7:0]         shade_in,
	input  logic [31:0]        life_period,
	input  logic [31:0]        life_elapsed,
	input  logic [23:0]        drag,
	input  logic [15:0]        time_step,
	input  pis_pkg::cfg_t      cfg,
	output logic               valid_s2,
	output pis_pkg::rec_t      rec_s2
);

	logic               valid_s1;
	logic [2:0][23:0]   pin_s1, vin_s1;
	logic signed [40:0] pv_s1 [3];
	logic [31:0]        esat_s1, period_s1, elapsed_s1;
	logic               expired_s1;
	logic [7:0]         shade_in_s1;
	logic [23:0]        drag_s1;
	logic [15:0]        dt_s1;
	logic signed [48:0] sdt_s1;

	logic [32:0]        esum;
	logic [31:0]        esat;
	logic signed [40:0] pv_c [3];
	logic signed [48:0] sdt_c;
	pis_pkg::rec_t      rec_c;

	// Stage 1: elapsed sum with saturation, velocity and strength products.
	always_comb begin
		esum = {1'b0, life_elapsed} + {17'd0, time_step};
		esat = esum[32] ? 32'hFFFFFFFF : esum[31:0];
		for (int k = 0; k < 3; k++) begin
			pv_c[k] = $signed(vel[k]) * $signed({1'b0, time_step});
		end
		sdt_c = $signed(cfg.strength) * $signed({1'b0, time_step});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pin_s1      <= pos;
			vin_s1      <= vel;
			pv_s1       <= pv_c;
			esat_s1     <= esat;
			expired_s1  <= esat > life_period;
			period_s1   <= life_period;
			elapsed_s1  <= life_elapsed;
			shade_in_s1 <= shade_in;
			drag_s1     <= drag;
			dt_s1       <= time_step;
			sdt_s1      <= sdt_c;
		end
	end

	// Stage 2: shade and elapsed update, position advance and grid edges.
	always_comb begin
		logic signed [8:0]  shade_c;
		logic [31:0]        enew;
		logic signed [48:0] qr;
		logic signed [40:0] rnd;
		logic signed [27:0] x, size, top;
		logic [23:0]        vv, vb;
		logic               flip;

		shade_c = $signed({1'b0, shade_in_s1})
			- $signed(expired_s1 ? {4'd0, cfg.shade_step} : 9'd0);
		enew = expired_s1 ? (esat_s1 - period_s1) : esat_s1;
		qr = sdt_s1 + 49'sd32768;

		rec_c.dead    = shade_c[8];
		rec_c.vin     = vin_s1;
		rec_c.shade   = rec_c.dead ? shade_in_s1 : shade_c[7:0];
		rec_c.elapsed = rec_c.dead ? elapsed_s1 : enew;
		rec_c.drag    = drag_s1;
		rec_c.dt      = dt_s1;
		rec_c.qs      = qr[47:16];

		for (int k = 0; k < 3; k++) begin
			rnd  = pv_s1[k] + 41'sd32768;
			x    = $signed({{4{pin_s1[k][23]}}, pin_s1[k]})
				+ $signed({{3{rnd[40]}}, rnd[40:16]});
			size = 28'(pis_pkg::grid_of(k) * 4096);
			top  = 28'((pis_pkg::grid_of(k) - 1) * 4096);
			vv   = vin_s1[k];
			vb   = (vv == 24'h800000) ? 24'h7FFFFF : (24'd0 - vv);
			flip = 1'b0;
			if (cfg.control[1:0] == pis_pkg::EDGE_WRAP) begin
				if (x < 0) x = x + size;
				else if (x >= size) x = x - size;
			end else if (x < 0 || x >= size) begin
				x = (x < 0) ? 28'sd0 : top;
				flip = (cfg.control[1:0] != pis_pkg::EDGE_CLAMP);
			end
			rec_c.p[k] = rec_c.dead ? pin_s1[k] : pis_pkg::sat24(48'(x));
			rec_c.v[k] = (flip && !rec_c.dead) ? vb : vv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s2 <= rec_c;
		end
	end

`ifndef SYNTHESIS
	// Clamped positions never go below zero.
	a_clamp_low: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rec_s2.dead && cfg.control[1:0] == pis_pkg::EDGE_CLAMP)
		|-> (!rec_s2.p[0][23] && !rec_s2.p[1][23] && !rec_s2.p[2][23]))
		else $error("clamped position below zero");
`endif

endmodule

// File: rtl/pis_drag.sv
// Stages 3 to 7: velocity-squared drag.
module pis_drag (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_s2,
	input  pis_pkg::rec_t      rec_s2,
	output logic               valid_s7,
	output pis_pkg::rec_t      rec_s7,
	output logic [2:0][24:0]   vd_s7
);

	logic valid_s3, valid_s4, valid_s5, valid_s6;
	pis_pkg::rec_t rec_s3, rec_s4, rec_s5, rec_s6;
	logic [46:0]        sq_s3 [3];
	logic [30:0]        vsq_s4;
	logic [19:0]        m_s5;
	logic signed [44:0] vm_s6 [3];

	logic signed [47:0] sqp [3];
	logic [48:0]        vsum;
	logic [54:0]        dprod;
	logic signed [44:0] vm_c [3];
	logic [2:0][24:0]   vd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Squares, their clamped sum, the drag factor and the per-axis scaling.
	always_comb begin
		logic signed [44:0] t;
		for (int k = 0; k < 3; k++) begin
			sqp[k]  = $signed(rec_s2.v[k]) * $signed(rec_s2.v[k]);
			vm_c[k] = $signed(rec_s5.v[k]) * $signed({1'b0, m_s5});
			t        = vm_s6[k] + 45'sd8388608;
			vd_c[k]  = $signed({rec_s6.v[k][23], rec_s6.v[k]})
				- $signed({{4{t[44]}}, t[44:24]});
		end
		vsum  = {2'd0, sq_s3[0]} + {2'd0, sq_s3[1]} + {2'd0, sq_s3[2]};
		dprod = vsq_s4 * rec_s4.drag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s3 <= rec_s2;
			rec_s4 <= rec_s3;
			rec_s5 <= rec_s4;
			rec_s6 <= rec_s5;
			rec_s7 <= rec_s6;
			for (int k = 0; k < 3; k++) begin
				sq_s3[k] <= sqp[k][46:0];
			end
			vsq_s4 <= (vsum > 49'(pis_pkg::VSQ_MAX)) ? pis_pkg::VSQ_MAX : vsum[30:0];
			m_s5   <= (dprod[54:24] > 31'(pis_pkg::MUL_MAX)) ? pis_pkg::MUL_MAX
				: dprod[43:24];
			vm_s6  <= vm_c;
			vd_s7  <= vd_c;
		end
	end

`ifndef SYNTHESIS
	// The drag factor never passes its limit.
	a_mul_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (m_s5 <= pis_pkg::MUL_MAX))
		else $error("drag factor over limit");
`endif

endmodule

// File: rtl/pis_attr.sv
// Stages 3 to 9: spring attractor toward a point or an axis.
module pis_attr (
	input  logic               clk,
	input  logic               adv,
	input  pis_pkg::cfg_t      cfg,
	input  pis_pkg::rec_t      rec_s2,
	output logic [2:0][43:0]   att_s9
);

	logic signed [24:0] d_s3 [3], d_s4 [3], d_s5 [3], d_s6 [3];
	logic signed [45:0] ad_s4 [3];
	logic signed [35:0] q_s5;
	logic signed [56:0] qa_s6 [3];
	logic [2:0][27:0]   a_s7;
	logic signed [59:0] aq_s8 [3];
	logic [31:0]        qs_s3, qs_s4, qs_s5, qs_s6, qs_s7;

	logic signed [24:0] d_c [3];
	logic signed [45:0] ad_c [3];
	logic signed [47:0] dot;
	logic signed [56:0] qa_c [3];
	logic [2:0][27:0]   a_c;
	logic signed [59:0] aq_c [3];
	logic [2:0][43:0]   att_c;

	// Offsets, axis projection, spring vector and strength scaling.
	always_comb begin
		logic signed [56:0] qt;
		logic signed [45:0] av;
		logic signed [59:0] at;
		dot = 48'sd2048;
		for (int k = 0; k < 3; k++) begin
			d_c[k]  = $signed({rec_s2.p[k][23], rec_s2.p[k]})
				- $signed({{4{cfg.apos[21*k+20]}}, cfg.apos[21*k +: 21]});
			ad_c[k] = $signed(cfg.aaxis[21*k +: 21]) * d_s3[k];
			dot     = dot + 48'(ad_s4[k]);
			qa_c[k] = q_s5 * $signed(cfg.aaxis[21*k +: 21]);
			qt      = qa_s6[k] + 57'sd2048;
			av      = cfg.control[pis_pkg::CTL_AXIS]
				? ($signed({qt[56], qt[56:12]}) - 46'(d_s6[k])) : (46'sd0 - 46'(d_s6[k]));
			a_c[k]  = pis_pkg::sat28(48'(av));
			aq_c[k] = $signed(a_s7[k]) * $signed(qs_s7);
			at      = aq_s8[k] + 60'sd32768;
			att_c[k] = cfg.control[pis_pkg::CTL_ATTRACT] ? at[59:16] : 44'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3   <= d_c;
			d_s4   <= d_s3;
			d_s5   <= d_s4;
			d_s6   <= d_s5;
			qs_s3  <= rec_s2.qs;
			qs_s4  <= qs_s3;
			qs_s5  <= qs_s4;
			qs_s6  <= qs_s5;
			qs_s7  <= qs_s6;
			ad_s4  <= ad_c;
			q_s5   <= dot[47:12];
			qa_s6  <= qa_c;
			a_s7   <= a_c;
			aq_s8  <= aq_c;
			att_s9 <= att_c;
		end
	end

endmodule

// File: rtl/pis_mag.sv
// Stages 8 to 12: magnetic force and the final velocity sum.
module pis_mag (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  pis_pkg::cfg_t      cfg,
	input  logic               valid_s7,
	input  pis_pkg::rec_t      rec_s7,
	input  logic [2:0][24:0]   vd_s7,
	input  logic [2:0][43:0]   att_s9,
	output logic               valid_s12,
	output pis_pkg::rec_t      rec_s12,
	output logic [2:0][23:0]   vel_s12
);

	logic valid_s8, valid_s9, valid_s10, valid_s11;
	pis_pkg::rec_t rec_s8, rec_s9, rec_s10, rec_s11;
	logic [2:0][24:0]   vd_s8, vd_s9, vd_s10, vd_s11;
	logic signed [45:0] bp_s8 [6];
	logic signed [46:0] cr_s9 [3];
	logic signed [63:0] cm_s10 [3];
	logic [2:0][35:0]   mag_s11;
	logic [2:0][43:0]   att_s10, att_s11;

	logic signed [45:0] bp_c [6];
	logic signed [46:0] cr_c [3];
	logic signed [63:0] cm_c [3];
	logic [2:0][35:0]   mag_c;
	logic [2:0][23:0]   vel_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else if (adv) begin
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
		end
	end

	// Cross product terms, time scaling, rounding and the saturated sum.
	always_comb begin
		logic signed [20:0] bx, by, bz;
		logic signed [63:0] mt;
		logic signed [47:0] sum;
		bx = $signed(cfg.magnetic[20:0]);
		by = $signed(cfg.magnetic[41:21]);
		bz = $signed(cfg.magnetic[62:42]);
		bp_c[0] = $signed(vd_s7[1]) * bz;
		bp_c[1] = $signed(vd_s7[2]) * by;
		bp_c[2] = $signed(vd_s7[2]) * bx;
		bp_c[3] = $signed(vd_s7[0]) * bz;
		bp_c[4] = $signed(vd_s7[0]) * by;
		bp_c[5] = $signed(vd_s7[1]) * bx;
		for (int k = 0; k < 3; k++) begin
			cr_c[k]  = 47'(bp_s8[2*k]) - 47'(bp_s8[2*k+1]);
			cm_c[k]  = cr_s9[k] * $signed({1'b0, rec_s9.dt});
			mt       = cm_s10[k] + 64'sd134217728;
			mag_c[k] = cfg.control[pis_pkg::CTL_MAGNETIC] ? mt[63:28] : 36'd0;
			sum      = 48'($signed(vd_s11[k])) + 48'($signed(mag_s11[k]))
				+ 48'($signed(att_s11[k]));
			vel_c[k] = rec_s11.dead ? rec_s11.vin[k] : pis_pkg::sat24(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s8  <= rec_s7;
			rec_s9  <= rec_s8;
			rec_s10 <= rec_s9;
			rec_s11 <= rec_s10;
			rec_s12 <= rec_s11;
			vd_s8   <= vd_s7;
			vd_s9   <= vd_s8;
			vd_s10  <= vd_s9;
			vd_s11  <= vd_s10;
			bp_s8   <= bp_c;
			cr_s9   <= cr_c;
			cm_s10  <= cm_c;
			mag_s11 <= mag_c;
			att_s10 <= att_s9;
			att_s11 <= att_s10;
			vel_s12 <= vel_c;
		end
	end

`ifndef SYNTHESIS
	// A dead particle leaves with its input velocity.
	a_dead_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s12 && rec_s12.dead) |-> (vel_s12 == rec_s12.vin))
		else $error("dead particle velocity not echoed");
`endif

endmodule

// File: rtl/particle_integrate_step.sv
// Top level of the particle integrator: one Euler step per particle record.
//
//  channel   signals                                   direction
//  input     in_valid / in_ready, particle fields        into block
//  output    out_valid / out_ready, updated fields       out of block
//  config    cfg_we, cfg_index, cfg_wdata                into block
//
// Twelve register stages; a beat is accepted in every cycle the output is free
// or being taken, so throughput is one record per clock.
// The whole pipe advances together when the last stage is empty or taken.
// Reset clears the stage valid bits and returns the configuration registers to
// their reset values.
// While out_valid waits on out_ready every stage holds its contents.
module particle_integrate_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [62:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_y,
	input  logic [23:0] pos_z,
	input  logic [23:0] vel_x,
	input  logic [23:0] vel_y,
	input  logic [23:0] vel_z,
	input  logic [7:0]  shade_in,
	input  logic [31:0] life_period,
	input  logic [31:0] life_elapsed,
	input  logic [23:0] drag,
	input  logic [15:0] time_step,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] new_pos_x,
	output logic [23:0] new_pos_y,
	output logic [23:0] new_pos_z,
	output logic [23:0] new_vel_x,
	output logic [23:0] new_vel_y,
	output logic [23:0] new_vel_z,
	output logic [7:0]  shade_out,
	output logic [31:0] new_life_elapsed,
	output logic        dead
);

	pis_pkg::cfg_t    cfg;
	pis_pkg::rec_t    rec_s2, rec_s7, rec_s12;
	logic             valid_s2, valid_s7, valid_s12, adv;
	logic [2:0][24:0] vd_s7;
	logic [2:0][43:0] att_s9;
	logic [2:0][23:0] vel_s12;

	// Global advance: the pipe moves when the output beat is absent or taken.
	assign adv      = !valid_s12 || out_ready;
	assign in_ready = adv;

	pis_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .cfg(cfg)
	);

	pis_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(in_valid),
		.pos({pos_z, pos_y, pos_x}), .vel({vel_z, vel_y, vel_x}),
		.shade_in(shade_in), .life_period(life_period), .life_elapsed(life_elapsed),
		.drag(drag), .time_step(time_step), .cfg(cfg),
		.valid_s2(valid_s2), .rec_s2(rec_s2)
	);

	pis_drag u_drag (
		.clk(clk), .arst_n(arst_n), .adv(adv), .valid_s2(valid_s2), .rec_s2(rec_s2),
		.valid_s7(valid_s7), .rec_s7(rec_s7), .vd_s7(vd_s7)
	);

	pis_attr u_attr (
		.clk(clk), .adv(adv), .cfg(cfg), .rec_s2(rec_s2), .att_s9(att_s9)
	);

	pis_mag u_mag (
		.clk(clk), .arst_n(arst_n), .adv(adv), .cfg(cfg), .valid_s7(valid_s7),
		.rec_s7(rec_s7), .vd_s7(vd_s7), .att_s9(att_s9),
		.valid_s12(valid_s12), .rec_s12(rec_s12), .vel_s12(vel_s12)
	);

	// Output beat.
	assign out_valid        = valid_s12;
	assign new_pos_x        = rec_s12.p[0];
	assign new_pos_y        = rec_s12.p[1];
	assign new_pos_z        = rec_s12.p[2];
	assign new_vel_x        = vel_s12[0];
	assign new_vel_y        = vel_s12[1];
	assign new_vel_z        = vel_s12[2];
	assign shade_out        = rec_s12.shade;
	assign new_life_elapsed = rec_s12.elapsed;
	assign dead             = rec_s12.dead;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the particle integrator: random and directed records.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] EDGE_BOUNCE   = 2'd2;
	localparam logic [2:0] REG_SPARE_LO  = 3'd6;
	localparam logic [2:0] REG_SPARE_HI  = 3'd7;
	localparam int         DRAIN_CYCLES  = 20;
	localparam int         RAND_PER_SET  = 100;
	localparam longint     GRID_SPAN     = longint'(pis_pkg::GRID_X) * 4096;

	typedef struct packed {
		logic [23:0] pos_x, pos_y, pos_z;
		logic [23:0] vel_x, vel_y, vel_z;
		logic [7:0]  shade_in;
		logic [31:0] life_period, life_elapsed;
		logic [23:0] drag;
		logic [15:0] time_step;
	} particle_in_t;

	typedef struct packed {
		logic [23:0] pos_x, pos_y, pos_z;
		logic [23:0] vel_x, vel_y, vel_z;
		logic [7:0]  shade;
		logic [31:0] elapsed;
		logic        dead;
	} particle_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [62:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [23:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic [7:0] shade_in = '0;
	logic [31:0] life_period = '0, life_elapsed = '0;
	logic [23:0] drag = '0;
	logic [15:0] time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [23:0] new_pos_x, new_pos_y, new_pos_z;
	logic [23:0] new_vel_x, new_vel_y, new_vel_z;
	logic [7:0] shade_out;
	logic [31:0] new_life_elapsed;
	logic dead;

	// Shadow copy of the configuration registers.
	logic [4:0]  ctl_q = 5'd0;
	logic [4:0]  shade_step_q = 5'd1;
	logic [62:0] field_q = '0;
	logic [62:0] apos_q = '0;
	logic [62:0] aaxis_q = '0;
	logic [31:0] strength_q = '0;

	particle_in_t  pending_particles[$];
	particle_out_t expected_updates[$];
	int err_cnt = 0;
	int beats_in = 0;
	int idle_mode = 0;

	particle_integrate_step dut (.*);

	always #1 clk = ~clk;

	function automatic longint rshr(longint x, int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint satw(longint x, int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		if (x > hi) return hi;
		if (x < -hi - 1) return -hi - 1;
		return x;
	endfunction

	function automatic longint part21(logic [62:0] packed_v, int k);
		logic signed [20:0] c;
		c = packed_v[21 * k +: 21];
		return longint'(c);
	endfunction

	// One Euler step of one record under the shadow configuration.
	function automatic particle_out_t integrate_particle(particle_in_t it);
		particle_out_t r;
		longint pin[3], vin[3], p[3], v[3], nv[3], a[3], d[3], cr[3];
		longint el, sh, dt, dg, vsq, mul, qs, dot, q, sz, g;
		logic [1:0] mode;
		pin[0] = longint'(signed'(it.pos_x));
		pin[1] = longint'(signed'(it.pos_y));
		pin[2] = longint'(signed'(it.pos_z));
		vin[0] = longint'(signed'(it.vel_x));
		vin[1] = longint'(signed'(it.vel_y));
		vin[2] = longint'(signed'(it.vel_z));
		dt = longint'(it.time_step);
		dg = longint'(it.drag);
		mode = ctl_q[1:0];

		// Lifetime: elapsed saturates, strict compare against the period.
		el = longint'(it.life_elapsed) + dt;
		if (el > 64'hFFFFFFFF) el = 64'hFFFFFFFF;
		sh = longint'(it.shade_in);
		if (el > longint'(it.life_period)) begin
			sh -= longint'(shade_step_q);
			el -= longint'(it.life_period);
		end
		if (sh < 0) begin
			r.pos_x = it.pos_x; r.pos_y = it.pos_y; r.pos_z = it.pos_z;
			r.vel_x = it.vel_x; r.vel_y = it.vel_y; r.vel_z = it.vel_z;
			r.shade = it.shade_in;
			r.elapsed = it.life_elapsed;
			r.dead = 1'b1;
			return r;
		end

		// Advance and treat the grid edges.
		for (int k = 0; k < 3; k++) begin
			g = longint'(pis_pkg::grid_of(k));
			sz = g * 4096;
			v[k] = vin[k];
			p[k] = pin[k] + rshr(v[k] * dt, 16);
			if (mode == pis_pkg::EDGE_WRAP) begin
				if (p[k] < 0) p[k] += sz;
				else if (p[k] >= sz) p[k] -= sz;
			end else if (p[k] < 0 || p[k] >= sz) begin
				p[k] = (p[k] < 0) ? 64'sd0 : (g - 1) * 4096;
				if (mode >= EDGE_BOUNCE) v[k] = satw(-v[k], 24);
			end
			p[k] = satw(p[k], 24);
		end

		// Quadratic drag.
		vsq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		if (vsq > longint'(pis_pkg::VSQ_MAX)) vsq = longint'(pis_pkg::VSQ_MAX);
		mul = (vsq * dg) >>> 24;
		if (mul > longint'(pis_pkg::MUL_MAX)) mul = longint'(pis_pkg::MUL_MAX);
		for (int k = 0; k < 3; k++) begin
			v[k] -= rshr(v[k] * mul, 24);
			nv[k] = v[k];
		end

		if (ctl_q[pis_pkg::CTL_MAGNETIC]) begin
			cr[0] = v[1] * part21(field_q, 2) - v[2] * part21(field_q, 1);
			cr[1] = v[2] * part21(field_q, 0) - v[0] * part21(field_q, 2);
			cr[2] = v[0] * part21(field_q, 1) - v[1] * part21(field_q, 0);
			for (int k = 0; k < 3; k++) nv[k] += rshr(cr[k] * dt, 28);
		end

		if (ctl_q[pis_pkg::CTL_ATTRACT]) begin
			qs = rshr(longint'(signed'(strength_q)) * dt, 16);
			if (ctl_q[pis_pkg::CTL_AXIS]) begin
				dot = 0;
				for (int k = 0; k < 3; k++) begin
					d[k] = p[k] - part21(apos_q, k);
					dot += part21(aaxis_q, k) * d[k];
				end
				q = rshr(dot, 12);
				for (int k = 0; k < 3; k++)
					a[k] = rshr(q * part21(aaxis_q, k), 12) - d[k];
			end else begin
				for (int k = 0; k < 3; k++) a[k] = part21(apos_q, k) - p[k];
			end
			for (int k = 0; k < 3; k++) nv[k] += rshr(satw(a[k], 28) * qs, 16);
		end

		r.pos_x = p[0][23:0]; r.pos_y = p[1][23:0]; r.pos_z = p[2][23:0];
		r.vel_x = 24'(satw(nv[0], 24));
		r.vel_y = 24'(satw(nv[1], 24));
		r.vel_z = 24'(satw(nv[2], 24));
		r.shade = sh[7:0];
		r.elapsed = el[31:0];
		r.dead = 1'b0;
		return r;
	endfunction

	function automatic logic [23:0] rand_pos();
		if ($urandom_range(0, 9) < 7)
			return 24'($urandom_range(0, 32'(GRID_SPAN + 16384)) - 8192);
		return 24'($urandom);
	endfunction

	function automatic logic [23:0] rand_vel();
		int r;
		r = int'($urandom_range(0, 9));
		if (r < 5) return 24'($urandom_range(0, 1 << 20) - (1 << 19));
		if (r < 7) return 24'($urandom_range(0, 1 << 16) - (1 << 15));
		return 24'($urandom);
	endfunction

	function automatic particle_in_t rand_particle();
		particle_in_t it;
		it.pos_x = rand_pos(); it.pos_y = rand_pos(); it.pos_z = rand_pos();
		it.vel_x = rand_vel(); it.vel_y = rand_vel(); it.vel_z = rand_vel();
		it.shade_in = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		it.time_step = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				it.life_period = $urandom;
				it.life_elapsed = $urandom;
			end
			1: begin
				it.life_period = $urandom_range(0, 1 << 18);
				it.life_elapsed = it.life_period - it.time_step + 32'($urandom_range(0, 4)) - 2;
			end
			default: begin
				it.life_period = $urandom_range(0, 1 << 17);
				it.life_elapsed = $urandom_range(0, 1 << 17);
			end
		endcase
		it.drag = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(0, 255)) : 24'($urandom);
		return it;
	endfunction

	// Directed records: field extremes, lifetime corners and edge crossings.
	task automatic queue_directed();
		particle_in_t it;
		it = '0;
		pending_particles.push_back(it);
		it = '1;
		pending_particles.push_back(it);
		it = '0;
		it.pos_x = 24'h800000; it.pos_y = 24'h7FFFFF; it.pos_z = 24'h800000;
		it.vel_x = 24'h7FFFFF; it.vel_y = 24'h800000; it.vel_z = 24'h7FFFFF;
		it.time_step = 16'hFFFF; it.drag = 24'hFFFFFF; it.shade_in = 8'hFF;
		it.life_period = 32'hFFFFFFFF;
		pending_particles.push_back(it);
		// Elapsed time saturates at the top.
		it.life_elapsed = 32'hFFFFFFFF; it.life_period = 32'hFFFFFFF0;
		pending_particles.push_back(it);
		// Elapsed exactly equal to the period does not expire.
		it = '0;
		it.life_period = 32'd5000; it.life_elapsed = 32'd4000; it.time_step = 16'd1000;
		pending_particles.push_back(it);
		it.time_step = 16'd1001;
		pending_particles.push_back(it);
		// Shade at zero with an expiring period kills the particle.
		it.shade_in = 8'd0; it.pos_x = 24'h123456; it.vel_y = 24'hABCDEF;
		pending_particles.push_back(it);
		it.shade_in = 8'd1;
		pending_particles.push_back(it);
		// Grid crossings below zero and at the top edge.
		it = '0;
		it.time_step = 16'h8000; it.life_period = 32'hFFFFFFFF; it.shade_in = 8'd9;
		it.pos_x = 24'd10; it.vel_x = -24'sd40960;
		it.pos_y = 24'(GRID_SPAN - 10); it.vel_y = 24'd40960;
		it.pos_z = 24'(GRID_SPAN); it.vel_z = 24'd0;
		pending_particles.push_back(it);
		it.pos_x = 24'hFFFFFF; it.vel_x = 24'd0; it.pos_y = 24'h7FFFFF;
		pending_particles.push_back(it);
		for (int i = 0; i < 10; i++) pending_particles.push_back(rand_particle());
	endtask

	task automatic write_reg(logic [2:0] idx, logic [62:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pis_pkg::REG_CONTROL:  ctl_q = val[4:0];
			pis_pkg::REG_SHADE:    shade_step_q = val[4:0];
			pis_pkg::REG_MAGNETIC: field_q = val;
			pis_pkg::REG_APOS:     apos_q = val;
			pis_pkg::REG_AAXIS:    aaxis_q = val;
			pis_pkg::REG_STRENGTH: strength_q = val[31:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_particles.size() != 0 || in_valid || expected_updates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom, $urandom});
	endfunction

	// Sender: a new beat goes out only when the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		particle_in_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_particles.size() != 0 &&
			    !(idle_mode == 0 && $urandom_range(0, 99) < 23) &&
			    !(idle_mode == 1 && $urandom_range(0, 99) < 63)) begin
				it = pending_particles.pop_front();
				in_valid <= 1'b1;
				pos_x <= it.pos_x; pos_y <= it.pos_y; pos_z <= it.pos_z;
				vel_x <= it.vel_x; vel_y <= it.vel_y; vel_z <= it.vel_z;
				shade_in <= it.shade_in;
				life_period <= it.life_period; life_elapsed <= it.life_elapsed;
				drag <= it.drag; time_step <= it.time_step;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold so the pipe backs up.
	always @(posedge clk or negedge arst_n) begin
		int hold_left;
		static bit held = 1'b0;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!held && beats_in == 350) begin
			held = 1'b1;
			hold_left = 300;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !((idle_mode == 0 && $urandom_range(0, 99) < 63) ||
			               (idle_mode == 1 && $urandom_range(0, 99) < 23));
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// Predict on each accepted input beat; compare each accepted output beat.
	always @(posedge clk) begin
		particle_in_t it;
		particle_out_t e;
		if (arst_n && in_valid && in_ready) begin
			it = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, shade_in,
			       life_period, life_elapsed, drag, time_step};
			expected_updates.push_back(integrate_particle(it));
			beats_in <= beats_in + 1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_updates.size() == 0) begin
				$error("output beat with no record outstanding");
				err_cnt++;
			end else begin
				e = expected_updates.pop_front();
				check_field("new_pos_x", 32'(e.pos_x), 32'(new_pos_x));
				check_field("new_pos_y", 32'(e.pos_y), 32'(new_pos_y));
				check_field("new_pos_z", 32'(e.pos_z), 32'(new_pos_z));
				check_field("new_vel_x", 32'(e.vel_x), 32'(new_vel_x));
				check_field("new_vel_y", 32'(e.vel_y), 32'(new_vel_y));
				check_field("new_vel_z", 32'(e.vel_z), 32'(new_vel_z));
				check_field("shade_out", 32'(e.shade), 32'(shade_out));
				check_field("new_life_elapsed", e.elapsed, new_life_elapsed);
				check_field("dead", 32'(e.dead), 32'(dead));
			end
		end
	end

	// Main sequence: one configuration set per phase, written while idle.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int ph = 0; ph < 7; ph++) begin
			idle_mode = (ph < 3) ? 0 : (ph < 5) ? 1 : 2;
			case (ph)
				0: begin
					// Spare indexes must not disturb the reset values.
					write_reg(REG_SPARE_LO, '1);
					write_reg(REG_SPARE_HI, rand63());
				end
				1: begin
					write_reg(pis_pkg::REG_CONTROL, {61'd0, pis_pkg::EDGE_CLAMP});
					write_reg(pis_pkg::REG_SHADE, 63'd0);
				end
				2: begin
					write_reg(pis_pkg::REG_CONTROL, 63'(4 | EDGE_BOUNCE));
					write_reg(pis_pkg::REG_SHADE, 63'd16);
					write_reg(pis_pkg::REG_MAGNETIC, rand63());
				end
				3: begin
					write_reg(pis_pkg::REG_CONTROL, 63'(8 | 3));
					write_reg(pis_pkg::REG_APOS, rand63());
					write_reg(pis_pkg::REG_STRENGTH, 63'($urandom_range(0, 1 << 20)));
				end
				4: begin
					write_reg(pis_pkg::REG_CONTROL, 63'(16 | 8 | 4 | EDGE_BOUNCE));
					write_reg(pis_pkg::REG_AAXIS, {21'd0, 21'd4096, 21'd0});
					write_reg(pis_pkg::REG_STRENGTH, 63'h7FFFFFFF);
				end
				5: begin
					write_reg(pis_pkg::REG_CONTROL, 63'd31);
					write_reg(pis_pkg::REG_SHADE, 63'd31);
					write_reg(pis_pkg::REG_MAGNETIC, {63{1'b1}});
					write_reg(pis_pkg::REG_APOS, {1'b0, 20'd0, 1'b1, 20'd0, 1'b1, 20'd0});
					write_reg(pis_pkg::REG_AAXIS, rand63());
					write_reg(pis_pkg::REG_STRENGTH, 63'h80000000);
				end
				default: begin
					write_reg(pis_pkg::REG_CONTROL, 63'($urandom_range(0, 31)));
					write_reg(pis_pkg::REG_SHADE, 63'($urandom_range(1, 16)));
					write_reg(pis_pkg::REG_MAGNETIC, rand63());
					write_reg(pis_pkg::REG_APOS, rand63());
					write_reg(pis_pkg::REG_AAXIS, rand63());
					write_reg(pis_pkg::REG_STRENGTH, 63'($urandom));
				end
			endcase
			if (ph == 0) queue_directed();
			for (int i = 0; i < RAND_PER_SET; i++) pending_particles.push_back(rand_particle());
			wait_drained();
		end
		if (err_cnt == 0 && expected_updates.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
